/* rtl/core/ttacc_pkg.sv */
package ttacc_pkg;

    // Default sizes of the slot and CPU tables
    localparam int MAX_SLOTS_DEF = 64;
    localparam int MAX_CPUS_DEF  = 8;

    // Counter width
    localparam int CNT_W = 64;

    // Configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPUS  = 1'b1;

    // Event codes on the action field
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_SWITCH  = 2'd1;
    localparam logic [1:0] ACT_RD_SLOT = 2'd2;
    localparam logic [1:0] ACT_RD_CPU  = 2'd3;

    // Classified operations handed from front to back
    typedef logic [2:0] op_t;
    localparam op_t OP_NONE      = 3'd0;
    localparam op_t OP_DROP      = 3'd1;
    localparam op_t OP_TICK_TASK = 3'd2;
    localparam op_t OP_TICK_IDLE = 3'd3;
    localparam op_t OP_SWITCH    = 3'd4;
    localparam op_t OP_RD_SLOT   = 3'd5;
    localparam op_t OP_RD_CPU    = 3'd6;

    // Queue depth between front and back
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        op_t              op;
        logic [7:0]       slot;
        logic [7:0]       cpu;
        logic [CNT_W-1:0] ready;
    } job_t;

endpackage

/* rtl/core/ttacc_ram.sv */
module ttacc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/ttacc_fifo.sv */
module ttacc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ttacc_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output ttacc_pkg::job_t head_job
);
    import ttacc_pkg::*;

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    job_t          mem_reg [Q_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/core/ttacc_front.sv */
module ttacc_front #(
    parameter int MAX_SLOTS = ttacc_pkg::MAX_SLOTS_DEF,
    parameter int MAX_CPUS  = ttacc_pkg::MAX_CPUS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ttacc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ttacc_pkg::CFG_W-1:0]      cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       action,
    input  logic [7:0]                       cpu,
    input  logic signed [8:0]                slot,
    input  logic                             is_idle_task,
    input  logic [ttacc_pkg::CNT_W-1:0]      ready_stamp,
    input  logic                             q_full,
    output logic                             push,
    output ttacc_pkg::job_t                  job,
    output logic [3:0]                       eff_cpus
);
    import ttacc_pkg::*;

    logic [6:0] slots_reg, slots_next;
    logic [3:0] cpus_reg, cpus_next;
    logic [7:0] eff_slots;
    logic [7:0] eff_cpus_w;
    logic       slot_ok;
    logic       cpu_ok;
    op_t        op;

    // Configuration registers
    always_comb
    begin
        slots_next = slots_reg;
        cpus_next  = cpus_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLOTS: slots_next = cfg_data;
                CFG_CPUS:  cpus_next  = cfg_data[3:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= '0;
            cpus_reg  <= '0;
        end
        else
        begin
            slots_reg <= slots_next;
            cpus_reg  <= cpus_next;
        end
    end

    // Clamp to table sizes
    assign eff_slots  = ({1'b0, slots_reg} > 8'(MAX_SLOTS)) ? 8'(MAX_SLOTS) : {1'b0, slots_reg};
    assign eff_cpus_w = ({4'b0, cpus_reg} > 8'(MAX_CPUS)) ? 8'(MAX_CPUS) : {4'b0, cpus_reg};
    assign eff_cpus   = eff_cpus_w[3:0];

    assign slot_ok = !slot[8] && (slot[7:0] < eff_slots);
    assign cpu_ok  = (cpu < eff_cpus_w);

    // Classify the event
    always_comb
    begin
        op = OP_NONE;
        case (action)
            ACT_TICK:
            begin
                if (eff_slots == '0)
                begin
                    op = OP_NONE;
                end
                else if (!cpu_ok)
                begin
                    op = OP_DROP;
                end
                else if (!slot_ok || is_idle_task)
                begin
                    op = OP_TICK_IDLE;
                end
                else
                begin
                    op = OP_TICK_TASK;
                end
            end
            ACT_SWITCH:  op = slot_ok ? OP_SWITCH : OP_NONE;
            ACT_RD_SLOT: op = slot_ok ? OP_RD_SLOT : OP_NONE;
            ACT_RD_CPU:  op = cpu_ok ? OP_RD_CPU : OP_NONE;
            default:     op = OP_NONE;
        endcase
    end

    assign in_ready  = !q_full;
    assign push      = in_valid && !q_full;
    assign job.op    = op;
    assign job.slot  = slot[7:0];
    assign job.cpu   = cpu;
    assign job.ready = ready_stamp;

endmodule

/* rtl/core/ttacc_back.sv */
module ttacc_back #(
    parameter int MAX_SLOTS = ttacc_pkg::MAX_SLOTS_DEF,
    parameter int MAX_CPUS  = ttacc_pkg::MAX_CPUS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [3:0]                  eff_cpus,
    input  logic                        head_valid,
    input  ttacc_pkg::job_t             head_job,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ttacc_pkg::CNT_W-1:0] seen_total,
    output logic [ttacc_pkg::CNT_W-1:0] charged_total,
    output logic [ttacc_pkg::CNT_W-1:0] idle_sum,
    output logic [ttacc_pkg::CNT_W-1:0] dropped_total,
    output logic                        balance_ok,
    output logic                        read_valid,
    output logic [ttacc_pkg::CNT_W-1:0] slot_ticks,
    output logic [ttacc_pkg::CNT_W-1:0] slot_switches,
    output logic [ttacc_pkg::CNT_W-1:0] slot_last_ran,
    output logic [ttacc_pkg::CNT_W-1:0] slot_longest_wait,
    output logic [ttacc_pkg::CNT_W-1:0] cpu_idle_ticks
);
    import ttacc_pkg::*;

    localparam int SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CPU_AW  = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_SKEW = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]           state_reg, state_next;
    job_t                 cur_reg, cur_next;
    logic                 hit_reg, hit_next;
    logic [MAX_SLOTS-1:0] slot_vld_reg, slot_vld_next;
    logic [CNT_W-1:0]     seen_reg, seen_next;
    logic [CNT_W-1:0]     charged_reg, charged_next;
    logic [CNT_W-1:0]     idle_sum_reg, idle_sum_next;
    logic [CNT_W-1:0]     dropped_reg, dropped_next;
    logic [CNT_W-1:0]     idle_reg [MAX_CPUS];
    logic [CNT_W-1:0]     idle_next [MAX_CPUS];
    logic                 out_valid_reg, out_valid_next;

    // Datapath words, no reset needed
    logic [CNT_W-1:0] wait_reg, wait_next;
    logic             meas_reg, meas_next;
    logic [CNT_W-1:0] lw_old_reg, lw_old_next;
    logic [CNT_W-1:0] parts_reg, parts_next;
    logic [CNT_W-1:0] skew_reg, skew_next;
    logic             rv_reg, rv_next;
    logic [CNT_W-1:0] rd_ticks_reg, rd_ticks_next;
    logic [CNT_W-1:0] rd_sw_reg, rd_sw_next;
    logic [CNT_W-1:0] rd_last_reg, rd_last_next;
    logic [CNT_W-1:0] rd_lw_reg, rd_lw_next;
    logic [CNT_W-1:0] rd_cpu_reg, rd_cpu_next;
    logic [CNT_W-1:0] o_seen_reg, o_charged_reg, o_idle_reg, o_dropped_reg;
    logic [CNT_W-1:0] o_ticks_reg, o_sw_reg, o_last_reg, o_lw_reg, o_cpu_reg;
    logic             o_bal_reg, o_rv_reg;

    // RAM ports
    logic [SLOT_AW-1:0] raddr, waddr;
    logic [CPU_AW-1:0]  cidx;
    logic               we_main, we_lw;
    logic [CNT_W-1:0]   q_tick, q_sw, q_last, q_lw;
    logic [CNT_W-1:0]   m_tick, m_sw, m_last, m_lw;
    logic [CNT_W-1:0]   w_tick, w_sw, w_last, w_lw;
    logic [CNT_W:0]     wdiff;
    logic [CNT_W:0]     pdiff;
    logic               load;

    assign raddr = head_job.slot[SLOT_AW-1:0];
    assign waddr = cur_reg.slot[SLOT_AW-1:0];
    assign cidx  = cur_reg.cpu[CPU_AW-1:0];
    assign pop   = (state_reg == S_IDLE) && head_valid;
    assign load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Never-written rows read as zero
    assign m_tick = q_tick & {CNT_W{hit_reg}};
    assign m_sw   = q_sw & {CNT_W{hit_reg}};
    assign m_last = q_last & {CNT_W{hit_reg}};
    assign m_lw   = q_lw & {CNT_W{hit_reg}};

    assign we_main = (state_reg == S_EXEC)
                     && ((cur_reg.op == OP_TICK_TASK) || (cur_reg.op == OP_SWITCH));
    assign we_lw   = we_main
                     || ((state_reg == S_WAIT) && meas_reg && (wait_reg > lw_old_reg));
    assign w_tick  = (cur_reg.op == OP_TICK_TASK) ? m_tick + 64'd1 : m_tick;
    assign w_sw    = (cur_reg.op == OP_SWITCH) ? m_sw + 64'd1 : m_sw;
    assign w_last  = (cur_reg.op == OP_SWITCH) ? seen_reg : m_last;
    assign w_lw    = (state_reg == S_WAIT) ? wait_reg : m_lw;

    assign wdiff = {1'b0, seen_reg} - {1'b0, cur_reg.ready};
    assign pdiff = {1'b0, parts_reg} - {1'b0, seen_reg};

    ttacc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SLOTS)) u_ram_tick (
        .clk(clk), .we(we_main), .waddr(waddr), .wdata(w_tick),
        .re(pop), .raddr(raddr), .rdata(q_tick)
    );
    ttacc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SLOTS)) u_ram_sw (
        .clk(clk), .we(we_main), .waddr(waddr), .wdata(w_sw),
        .re(pop), .raddr(raddr), .rdata(q_sw)
    );
    ttacc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SLOTS)) u_ram_last (
        .clk(clk), .we(we_main), .waddr(waddr), .wdata(w_last),
        .re(pop), .raddr(raddr), .rdata(q_last)
    );
    ttacc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SLOTS)) u_ram_lw (
        .clk(clk), .we(we_lw), .waddr(waddr), .wdata(w_lw),
        .re(pop), .raddr(raddr), .rdata(q_lw)
    );

    // Sequencer and counter updates
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        hit_next       = hit_reg;
        slot_vld_next  = slot_vld_reg;
        seen_next      = seen_reg;
        charged_next   = charged_reg;
        idle_sum_next  = idle_sum_reg;
        dropped_next   = dropped_reg;
        for (int i = 0; i < MAX_CPUS; i++)
        begin
            idle_next[i] = idle_reg[i];
        end
        wait_next      = wait_reg;
        meas_next      = meas_reg;
        lw_old_next    = lw_old_reg;
        parts_next     = parts_reg;
        skew_next      = skew_reg;
        rv_next        = rv_reg;
        rd_ticks_next  = rd_ticks_reg;
        rd_sw_next     = rd_sw_reg;
        rd_last_next   = rd_last_reg;
        rd_lw_next     = rd_lw_reg;
        rd_cpu_next    = rd_cpu_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    cur_next   = head_job;
                    hit_next   = slot_vld_reg[raddr];
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                rv_next       = 1'b0;
                rd_ticks_next = '0;
                rd_sw_next    = '0;
                rd_last_next  = '0;
                rd_lw_next    = '0;
                rd_cpu_next   = '0;
                state_next    = S_SUM;
                case (cur_reg.op)
                    OP_DROP:
                    begin
                        dropped_next = dropped_reg + 64'd1;
                    end
                    OP_TICK_TASK:
                    begin
                        seen_next           = seen_reg + 64'd1;
                        charged_next        = charged_reg + 64'd1;
                        slot_vld_next[waddr] = 1'b1;
                    end
                    OP_TICK_IDLE:
                    begin
                        seen_next       = seen_reg + 64'd1;
                        idle_sum_next   = idle_sum_reg + 64'd1;
                        idle_next[cidx] = idle_reg[cidx] + 64'd1;
                    end
                    OP_SWITCH:
                    begin
                        slot_vld_next[waddr] = 1'b1;
                        wait_next   = wdiff[CNT_W-1:0];
                        meas_next   = (cur_reg.ready != '0) && !wdiff[CNT_W]
                                      && (wdiff[CNT_W-1:0] != '0);
                        lw_old_next = m_lw;
                        state_next  = S_WAIT;
                    end
                    OP_RD_SLOT:
                    begin
                        rv_next       = 1'b1;
                        rd_ticks_next = m_tick;
                        rd_sw_next    = m_sw;
                        rd_last_next  = m_last;
                        rd_lw_next    = m_lw;
                    end
                    OP_RD_CPU:
                    begin
                        rv_next     = 1'b1;
                        rd_cpu_next = idle_reg[cidx];
                    end
                    default: ;
                endcase
            end
            S_WAIT:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                parts_next = charged_reg + idle_sum_reg;
                state_next = S_SKEW;
            end
            S_SKEW:
            begin
                skew_next  = pdiff[CNT_W] ? seen_reg - parts_reg : pdiff[CNT_W-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_vld_reg  <= '0;
            seen_reg      <= '0;
            charged_reg   <= '0;
            idle_sum_reg  <= '0;
            dropped_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CPUS; i++)
            begin
                idle_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            slot_vld_reg  <= slot_vld_next;
            seen_reg      <= seen_next;
            charged_reg   <= charged_next;
            idle_sum_reg  <= idle_sum_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < MAX_CPUS; i++)
            begin
                idle_reg[i] <= idle_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        hit_reg      <= hit_next;
        wait_reg     <= wait_next;
        meas_reg     <= meas_next;
        lw_old_reg   <= lw_old_next;
        parts_reg    <= parts_next;
        skew_reg     <= skew_next;
        rv_reg       <= rv_next;
        rd_ticks_reg <= rd_ticks_next;
        rd_sw_reg    <= rd_sw_next;
        rd_last_reg  <= rd_last_next;
        rd_lw_reg    <= rd_lw_next;
        rd_cpu_reg   <= rd_cpu_next;
        if (load)
        begin
            o_seen_reg    <= seen_reg;
            o_charged_reg <= charged_reg;
            o_idle_reg    <= idle_sum_reg;
            o_dropped_reg <= dropped_reg;
            o_bal_reg     <= (skew_reg <= {{(CNT_W-4){1'b0}}, eff_cpus});
            o_rv_reg      <= rv_reg;
            o_ticks_reg   <= rd_ticks_reg;
            o_sw_reg      <= rd_sw_reg;
            o_last_reg    <= rd_last_reg;
            o_lw_reg      <= rd_lw_reg;
            o_cpu_reg     <= rd_cpu_reg;
        end
    end

    // Output word
    assign out_valid         = out_valid_reg;
    assign seen_total        = o_seen_reg;
    assign charged_total     = o_charged_reg;
    assign idle_sum          = o_idle_reg;
    assign dropped_total     = o_dropped_reg;
    assign balance_ok        = o_bal_reg;
    assign read_valid        = o_rv_reg;
    assign slot_ticks        = o_ticks_reg;
    assign slot_switches     = o_sw_reg;
    assign slot_last_ran     = o_last_reg;
    assign slot_longest_wait = o_lw_reg;
    assign cpu_idle_ticks    = o_cpu_reg;

`ifndef SYNTH
    // seen total only steps by one, and only while an event executes
    a_seen_step: assert property (@(posedge clk) disable iff (!rst_n)
        (seen_reg != $past(seen_reg)) |->
        (($past(state_reg) == S_EXEC) && (seen_reg == $past(seen_reg) + 64'd1)))
        else $error("seen total moved outside an accepted tick");

    // charged or idle never moves without the seen total
    a_charge_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
        ((charged_reg != $past(charged_reg)) || (idle_sum_reg != $past(idle_sum_reg)))
        |-> (seen_reg != $past(seen_reg)))
        else $error("tick charged without being counted as seen");

    // a finished word waits while the output is stalled
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("result overwritten while output stalled");
`endif

endmodule

/* rtl/core/task_tick_accounting_top.sv */
// Per-task CPU time accounting.
// Input channel (in_valid/in_ready) takes one event word: action, cpu, slot,
// is_idle_task and ready_stamp. Output channel (out_valid/out_ready) returns
// exactly one result word per event: the four running totals, the balance
// check, and for reads the slot counters or the CPU idle count.
// Configuration: cfg_we with cfg_index 0 writes slots_in_use, index 1 writes
// cpus_in_use; write only while no event is in flight.
// The back-end sequencer takes one event at a time: it reads the slot row
// from the counter RAMs, updates it (a switch adds a step that writes the
// longest wait), then forms charged plus idle and its distance to seen, one
// wide add per cycle, and loads the result word into the output register.
// A two-entry queue sits between the classifier and the sequencer, so up to
// three further events are taken while a result waits (one in the sequencer,
// two in the queue); when the receiver stalls, the finished word holds in the
// output register and the queue fills until in_ready drops.
// Reset clears every counter, the slot row valid bits and both registers, so
// ticks and switches are ignored until slots_in_use is written nonzero.
module task_tick_accounting_top #(
    parameter int MAX_SLOTS = ttacc_pkg::MAX_SLOTS_DEF,
    parameter int MAX_CPUS  = ttacc_pkg::MAX_CPUS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ttacc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ttacc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      action,
    input  logic [7:0]                      cpu,
    input  logic signed [8:0]               slot,
    input  logic                            is_idle_task,
    input  logic [ttacc_pkg::CNT_W-1:0]     ready_stamp,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ttacc_pkg::CNT_W-1:0]     seen_total,
    output logic [ttacc_pkg::CNT_W-1:0]     charged_total,
    output logic [ttacc_pkg::CNT_W-1:0]     idle_sum,
    output logic [ttacc_pkg::CNT_W-1:0]     dropped_total,
    output logic                            balance_ok,
    output logic                            read_valid,
    output logic [ttacc_pkg::CNT_W-1:0]     slot_ticks,
    output logic [ttacc_pkg::CNT_W-1:0]     slot_switches,
    output logic [ttacc_pkg::CNT_W-1:0]     slot_last_ran,
    output logic [ttacc_pkg::CNT_W-1:0]     slot_longest_wait,
    output logic [ttacc_pkg::CNT_W-1:0]     cpu_idle_ticks
);
    import ttacc_pkg::*;

    logic       q_full;
    logic       push;
    job_t       push_job;
    logic       pop;
    logic       head_valid;
    job_t       head_job;
    logic [3:0] eff_cpus;

    // Classifier and configuration
    ttacc_front #(.MAX_SLOTS(MAX_SLOTS), .MAX_CPUS(MAX_CPUS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .cpu(cpu), .slot(slot),
        .is_idle_task(is_idle_task), .ready_stamp(ready_stamp),
        .q_full(q_full), .push(push), .job(push_job), .eff_cpus(eff_cpus)
    );

    // Event queue
    ttacc_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_job(push_job), .full(q_full),
        .pop(pop), .head_valid(head_valid), .head_job(head_job)
    );

    // Counter update sequencer
    ttacc_back #(.MAX_SLOTS(MAX_SLOTS), .MAX_CPUS(MAX_CPUS)) u_back (
        .clk(clk), .rst_n(rst_n), .eff_cpus(eff_cpus),
        .head_valid(head_valid), .head_job(head_job), .pop(pop),
        .out_valid(out_valid), .out_ready(out_ready),
        .seen_total(seen_total), .charged_total(charged_total),
        .idle_sum(idle_sum), .dropped_total(dropped_total),
        .balance_ok(balance_ok), .read_valid(read_valid),
        .slot_ticks(slot_ticks), .slot_switches(slot_switches),
        .slot_last_ran(slot_last_ran), .slot_longest_wait(slot_longest_wait),
        .cpu_idle_ticks(cpu_idle_ticks)
    );

endmodule
